>>> hw/rtl/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg: shared types and constants for the sorted key table
// Payload structs, operation and status codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sti_pkg;

  // Operation codes carried in the request word
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // Status codes carried in the response word
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // Register file
  localparam int unsigned APB_AW       = 3;
  localparam logic [APB_AW-1:0] REG_CAP_ADDR = 3'd0;
  localparam logic [5:0] CAP_RESET     = 6'd32;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key_value;
    logic [4:0]  position;
  } req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [5:0]  entry_count;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_RD,
    ST_INS_WR,
    ST_REM_RD,
    ST_REM_WR,
    ST_LKP_RD,
    ST_LKP_WAIT,
    ST_RESULT
  } sti_state_t;

  // Memory read address relative to the index register
  typedef enum logic [1:0] {
    RD_AT,
    RD_BELOW,
    RD_ABOVE
  } rd_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       idx_load_cnt;
    logic       idx_load_pos;
    logic       idx_dec;
    logic       idx_inc;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_en;
    logic       wr_key;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_clear;
    logic       res_err;
    logic [1:0] err_code;
    logic       res_capture;
    logic       out_load;
  } sti_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       pos_bad;
    logic       idx_zero;
    logic       rd_less;
    logic       rem_end;
    logic       out_free;
  } sti_stat_t;

endpackage

>>> hw/rtl/sti_dpath.sv
// ----------------------------------------------------------------------------
// sti_dpath: key storage, counters and response register
// Holds the key memory, the entry count, the walk index, the latched
// request and the response register. Acts only on controller commands.
// ----------------------------------------------------------------------------
module sti_dpath #(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  sti_pkg::req_t     req,
  input  logic [5:0]        cap,
  input  sti_pkg::sti_cmd_t cmd,
  output sti_pkg::sti_stat_t stat,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output sti_pkg::rsp_t     rsp
);
  import sti_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (IW > 6) ? IW : 6;

  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic [KEY_WIDTH-1:0] rd_data;
  logic [AW-1:0]        rd_addr;
  logic [IW-1:0]        rd_idx;

  logic [1:0]           mode_reg;
  logic [KEY_WIDTH-1:0] key_reg;
  logic [4:0]           pos_reg;
  logic [IW-1:0]        count;
  logic [IW-1:0]        idx;
  logic [31:0]          res_value;
  logic [1:0]           res_status;

  logic [KEY_WIDTH+31:0] key_wide;
  logic [KEY_WIDTH+31:0] val_wide;
  logic [IW+5:0]         cnt_wide;
  logic [IW:0]           idx_plus;
  logic [KEY_WIDTH-1:0]  wr_data;

  // Fit the request key to the stored width, and the stored key to the port
  assign key_wide = {{KEY_WIDTH{1'b0}}, req.key_value};
  assign val_wide = {32'd0, rd_data};
  assign cnt_wide = {6'd0, count};

  // Latch the request word
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_reg <= req.mode;
      key_reg  <= key_wide[KEY_WIDTH-1:0];
      pos_reg  <= req.position;
    end
  end

  // Select the read address around the walk index
  always_comb begin
    case (cmd.rd_sel)
      RD_BELOW: rd_idx = idx - 1'b1;
      RD_ABOVE: rd_idx = idx + 1'b1;
      default:  rd_idx = idx;
    endcase
  end
  assign rd_addr = rd_idx[AW-1:0];
  assign wr_data = cmd.wr_key ? key_reg : rd_data;

  // Key memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[idx[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + 1'b1;
    end else if (cmd.cnt_dec) begin
      count <= count - 1'b1;
    end
  end

  // Walk index
  always_ff @(posedge clk) begin
    if (cmd.idx_load_cnt) begin
      idx <= count;
    end else if (cmd.idx_load_pos) begin
      idx <= IW'(pos_reg);
    end else if (cmd.idx_dec) begin
      idx <= idx - 1'b1;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // Build the result; an error carries a zero value
  always_ff @(posedge clk) begin
    if (cmd.res_clear) begin
      res_value  <= '0;
      res_status <= STAT_OK;
    end else if (cmd.res_err) begin
      res_value  <= '0;
      res_status <= cmd.err_code;
    end else if (cmd.res_capture) begin
      res_value <= val_wide[31:0];
    end
  end

  // Response register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.read_value  <= res_value;
      rsp.status      <= res_status;
      rsp.entry_count <= cnt_wide[5:0];
    end
  end

  // Status back to the controller
  assign idx_plus = {1'b0, idx} + 1'b1;

  always_comb begin
    stat.mode     = mode_reg;
    stat.full     = (CW'(count) >= CW'(cap)) || (count >= IW'(DEPTH));
    stat.pos_bad  = (CW'(pos_reg) >= CW'(count));
    stat.idx_zero = (idx == '0);
    stat.rd_less  = (rd_data < key_reg);
    stat.rem_end  = (idx_plus >= {1'b0, count});
    stat.out_free = !rsp_valid || rsp_ready;
  end

endmodule

>>> hw/rtl/sti_ctrl.sv
// ----------------------------------------------------------------------------
// sti_ctrl: sequencer for insert, lookup and remove
// Walks the table one entry per read and write pair and issues the
// datapath commands for each step.
// ----------------------------------------------------------------------------
module sti_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  sti_pkg::sti_stat_t stat,
  output sti_pkg::sti_cmd_t  cmd
);
  import sti_pkg::*;

  sti_state_t state;
  sti_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_AT;
    req_ready  = 1'b0;

    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end

      ST_DECODE: begin
        cmd.res_clear = 1'b1;
        unique case (stat.mode)
          MODE_INSERT: begin
            if (stat.full) begin
              state_next = ST_RESULT;
            end else begin
              cmd.idx_load_cnt = 1'b1;
              state_next       = ST_INS_RD;
            end
          end
          MODE_LOOKUP: begin
            if (stat.pos_bad) begin
              state_next = ST_RESULT;
            end else begin
              cmd.idx_load_pos = 1'b1;
              state_next       = ST_LKP_RD;
            end
          end
          MODE_REMOVE: begin
            if (stat.pos_bad) begin
              state_next = ST_RESULT;
            end else begin
              cmd.idx_load_pos = 1'b1;
              state_next       = ST_REM_RD;
            end
          end
          default: begin
            state_next = ST_RESULT;
          end
        endcase
      end

      // Insert: walk down from the top, moving larger entries up one place
      ST_INS_RD: begin
        if (stat.idx_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_key  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = ST_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_BELOW;
          state_next = ST_INS_WR;
        end
      end

      ST_INS_WR: begin
        cmd.wr_en = 1'b1;
        if (stat.rd_less) begin
          cmd.wr_key  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = ST_RESULT;
        end else begin
          cmd.idx_dec = 1'b1;
          state_next  = ST_INS_RD;
        end
      end

      // Remove: walk up from the position, moving later entries down
      ST_REM_RD: begin
        if (stat.rem_end) begin
          cmd.cnt_dec = 1'b1;
          state_next  = ST_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ABOVE;
          state_next = ST_REM_WR;
        end
      end

      ST_REM_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = ST_REM_RD;
      end

      ST_LKP_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_LKP_WAIT;
      end

      ST_LKP_WAIT: begin
        cmd.res_capture = 1'b1;
        state_next      = ST_RESULT;
      end

      // Hand the result to the response register once it is free
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Flag errors during decode
    if (state == ST_DECODE) begin
      if ((stat.mode == MODE_INSERT) && stat.full) begin
        cmd.res_err  = 1'b1;
        cmd.err_code = STAT_FULL;
      end else if (((stat.mode == MODE_LOOKUP) || (stat.mode == MODE_REMOVE))
                   && stat.pos_bad) begin
        cmd.res_err  = 1'b1;
        cmd.err_code = STAT_RANGE;
      end
      if (cmd.res_err) begin
        cmd.res_clear = 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/sorted_table_insert_remove.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_remove: sorted key table with insert and remove
// Keeps keys in ascending unsigned order; inserts by position search and
// shift, looks up and removes by position. Capacity is set over APB.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Word
//   req      in         req_valid / req_ready  mode, key_value, position
//   rsp      out        rsp_valid / rsp_ready  read_value, status, entry_count
//   apb      in         psel/penable, pready   capacity_limit at offset 0
//
// One request at a time. Each entry moved takes a memory read, then a
// write. Reset clears the count and the response valid flag; the key memory
// is not cleared. A stalled response holds in its register while the next
// request is taken; that request then waits in its final step until the
// word leaves.
// ----------------------------------------------------------------------------
module sorted_table_insert_remove #(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  sti_pkg::req_t              req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output sti_pkg::rsp_t              rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sti_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import sti_pkg::*;

  logic [5:0] cap;
  logic       cfg_wr;
  sti_cmd_t   cmd;
  sti_stat_t  stat;

  // Capacity register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_wr && (paddr == REG_CAP_ADDR)) begin
      cap <= pwdata[5:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_CAP_ADDR) begin
      prdata = {26'd0, cap};
    end
  end

  sti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sti_dpath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cap       (cap),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

>>> hw/rtl/sti_checker.sv
// ----------------------------------------------------------------------------
// sti_checker: port-level checks for the sorted key table
// Watches the request, response and register ports over time.
// ----------------------------------------------------------------------------
module sti_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input sti_pkg::rsp_t rsp,
  input logic          pready
);
  import sti_pkg::*;

  // Hold a stalled response word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  // Drop ready after taking a request
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

  // Return a zero value with every error
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != STAT_OK) |-> rsp.read_value == 32'd0)
    else $error("error response carries a value");

  // Show no response straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid after reset");

  // Keep the register port ready
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind sorted_table_insert_remove sti_checker u_sti_checker (.*);
